/* src/mbc_pkg.sv */
// Package for the maze backtracker carver: types, codes and defaults.
// Used by maze_backtracker_carver; depends on nothing else.
package mbc_pkg;
    localparam int MBC_MAX_ROWS = 32;
    localparam int MBC_MAX_COLS = 32;
    localparam int CFG_W = 6;
    localparam int CMP_W = 10;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic MODE_START = 1'b0;

    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_CARVE  = 2'd1;
    localparam logic [1:0] EV_FINISH = 2'd2;

    localparam logic [1:0] SIDE_N = 2'd0;
    localparam logic [1:0] SIDE_W = 2'd1;
    localparam logic [1:0] SIDE_S = 2'd2;
    localparam logic [1:0] SIDE_E = 2'd3;

    localparam logic [2:0] CELL_SEEN  = 3'b001;
    localparam logic [2:0] CELL_DOWN  = 3'b010;
    localparam logic [2:0] CELL_RIGHT = 3'b100;
    localparam logic [2:0] CELL_FRESH = 3'b110;

    typedef enum logic [2:0] {
        S_CLEAR, S_START, S_IDLE, S_TOPRD, S_NBRD, S_PICK, S_WTOP, S_FIN
    } t_state;

    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [1:0] m;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        case (s)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
            default:                       m = 2'd2;
        endcase
        return m;
    endfunction
endpackage

/* src/maze_backtracker_carver.sv */
// Maze carver by the recursive backtracker, with cell and path memories.
// Depends on mbc_pkg.
// A start's result waits for the clearing sweep of the cell memory; a step's result waits for the
// five reads of the single cell memory read port per stack top, repeated for each dead-end cell
// popped; a step that empties the stack reports a finish once the last cell is popped.
// After a south or east carve the from cell's wall is written back before the next item is taken.
// After reset the cell memory is swept before an item is taken.
module maze_backtracker_carver import mbc_pkg::*; #(
    parameter int MAX_ROWS = MBC_MAX_ROWS,
    parameter int MAX_COLS = MBC_MAX_COLS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_mode,
    input  logic [4:0]       i_start_row,
    input  logic [4:0]       i_start_col,
    input  logic [7:0]       i_random_pick,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_event_res,
    output logic [4:0]       o_cell_row,
    output logic [4:0]       o_cell_col,
    output logic [4:0]       o_from_row,
    output logic [4:0]       o_from_col,
    output logic [1:0]       o_opened_side
);
    localparam int TOTAL = MAX_ROWS * MAX_COLS;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int DW = $clog2(TOTAL + 1);

    logic [2:0]     r_cell_mem [TOTAL];
    logic [RW+CW-1:0] r_stk_mem [TOTAL];

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_rows_cfg, r_cols_cfg;
    logic [AW-1:0] r_cnt, n_cnt;
    logic r_pend, n_pend;
    logic r_running, n_running;
    logic [DW-1:0] r_depth, n_depth;
    logic [7:0] r_pick, n_pick;
    logic [RW-1:0] r_sr, n_sr;
    logic [CW-1:0] r_sc, n_sc;
    logic [2:0] r_k, n_k;
    logic [3:0] r_mask, n_mask;
    logic [2:0] r_topv, n_topv;
    logic [1:0] n_side;
    logic [2:0] r_cell_q;
    logic [RW+CW-1:0] r_stk_q;

    logic r_ovalid, n_ovalid;
    logic [1:0] r_ev, n_ev, r_oside, n_oside;
    logic [4:0] r_crow, n_crow, r_ccol, n_ccol, r_frow, n_frow, r_fcol, n_fcol;

    logic cell_we;
    logic [AW-1:0] cell_waddr, cell_raddr;
    logic [2:0] cell_wdata;
    logic stk_we;
    logic [AW-1:0] stk_waddr, stk_raddr;
    logic [RW+CW-1:0] stk_wdata;

    logic [CMP_W-1:0] rows, cols;
    logic [RW-1:0] top_r, nb_r;
    logic [CW-1:0] top_c, nb_c;
    logic [3:0] nb_ok;
    logic out_busy;
    logic [2:0] cand_n;
    logic [1:0] sel, cnt_seen;
    logic [RW-1:0] pk_r;
    logic [CW-1:0] pk_c;

    function automatic logic [AW-1:0] cidx(input logic [RW-1:0] rr, input logic [CW-1:0] cc);
        return AW'(AW'(rr) * AW'(MAX_COLS) + AW'(cc));
    endfunction

    always_comb begin
        rows = (r_rows_cfg == '0) ? CMP_W'(1) :
               ((CMP_W'(r_rows_cfg) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : CMP_W'(r_rows_cfg));
        cols = (r_cols_cfg == '0) ? CMP_W'(1) :
               ((CMP_W'(r_cols_cfg) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : CMP_W'(r_cols_cfg));
        top_r = r_stk_q[RW+CW-1:CW];
        top_c = r_stk_q[CW-1:0];
        nb_ok[0] = (top_r != '0);
        nb_ok[1] = (top_c != '0);
        nb_ok[2] = (CMP_W'(top_r) + CMP_W'(1) < rows);
        nb_ok[3] = (CMP_W'(top_c) + CMP_W'(1) < cols);
        nb_r = top_r;
        nb_c = top_c;
        case (r_k)
            3'd0:    if (nb_ok[0]) nb_r = top_r - RW'(1);
            3'd1:    if (nb_ok[1]) nb_c = top_c - CW'(1);
            3'd2:    if (nb_ok[2]) nb_r = top_r + RW'(1);
            3'd3:    if (nb_ok[3]) nb_c = top_c + CW'(1);
            default: ;
        endcase
        cand_n = 3'(r_mask[0]) + 3'(r_mask[1]) + 3'(r_mask[2]) + 3'(r_mask[3]);
        case (cand_n)
            3'd2:    sel = {1'b0, r_pick[0]};
            3'd3:    sel = mod3(r_pick);
            3'd4:    sel = r_pick[1:0];
            default: sel = 2'd0;
        endcase
    end

    always_comb begin
        n_side = SIDE_N;
        cnt_seen = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (r_mask[i]) begin
                if (cnt_seen == sel) n_side = 2'(i);
                cnt_seen = cnt_seen + 2'd1;
            end
        end
        pk_r = top_r;
        pk_c = top_c;
        case (n_side)
            SIDE_N:  pk_r = top_r - RW'(1);
            SIDE_W:  pk_c = top_c - CW'(1);
            SIDE_S:  pk_r = top_r + RW'(1);
            default: pk_c = top_c + CW'(1);
        endcase
    end

    assign out_busy = r_ovalid && !i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign stk_raddr = AW'(r_depth - DW'(1));

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pend = r_pend;
        n_running = r_running;
        n_depth = r_depth;
        n_pick = r_pick;
        n_sr = r_sr;
        n_sc = r_sc;
        n_k = r_k;
        n_mask = r_mask;
        n_topv = r_topv;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ev = r_ev;
        n_oside = r_oside;
        n_crow = r_crow;
        n_ccol = r_ccol;
        n_frow = r_frow;
        n_fcol = r_fcol;
        cell_we = 1'b0;
        cell_waddr = r_cnt;
        cell_wdata = CELL_FRESH;
        cell_raddr = cidx(nb_r, nb_c);
        stk_we = 1'b0;
        stk_waddr = AW'(r_depth);
        stk_wdata = {pk_r, pk_c};
        unique case (r_state)
            S_CLEAR: begin
                cell_we = 1'b1;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(TOTAL - 1)) begin
                    n_state = r_pend ? S_START : S_IDLE;
                end
            end
            S_START: begin
                if (!out_busy) begin
                    cell_we = 1'b1;
                    cell_waddr = cidx(r_sr, r_sc);
                    cell_wdata = CELL_FRESH | CELL_SEEN;
                    stk_we = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {r_sr, r_sc};
                    n_depth = DW'(1);
                    n_running = 1'b1;
                    n_ovalid = 1'b1;
                    n_ev = EV_START;
                    n_crow = 5'(r_sr);
                    n_ccol = 5'(r_sc);
                    n_frow = '0;
                    n_fcol = '0;
                    n_oside = SIDE_N;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pick = i_random_pick;
                    if (i_mode == MODE_START) begin
                        n_sr = (CMP_W'(i_start_row) > rows - CMP_W'(1)) ?
                               RW'(rows - CMP_W'(1)) : RW'(i_start_row);
                        n_sc = (CMP_W'(i_start_col) > cols - CMP_W'(1)) ?
                               CW'(cols - CMP_W'(1)) : CW'(i_start_col);
                        n_cnt = '0;
                        n_pend = 1'b1;
                        n_state = S_CLEAR;
                    end else if (r_running && r_depth != '0) begin
                        n_state = S_TOPRD;
                    end else begin
                        n_running = 1'b0;
                        n_state = S_FIN;
                    end
                end
            end
            S_TOPRD: begin
                n_k = '0;
                n_mask = '0;
                n_state = S_NBRD;
            end
            S_NBRD: begin
                n_k = r_k + 3'd1;
                case (r_k)
                    3'd1:    n_mask[0] = nb_ok[0] && !r_cell_q[0];
                    3'd2:    n_mask[1] = nb_ok[1] && !r_cell_q[0];
                    3'd3:    n_mask[2] = nb_ok[2] && !r_cell_q[0];
                    3'd4:    n_mask[3] = nb_ok[3] && !r_cell_q[0];
                    3'd5:    n_topv = r_cell_q;
                    default: ;
                endcase
                if (r_k == 3'd5) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (cand_n == '0) begin
                    n_depth = r_depth - DW'(1);
                    if (r_depth == DW'(1)) begin
                        n_running = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_TOPRD;
                    end
                end else if (!out_busy) begin
                    cell_we = 1'b1;
                    cell_waddr = cidx(pk_r, pk_c);
                    cell_wdata = CELL_FRESH | CELL_SEEN;
                    if (n_side == SIDE_N) cell_wdata = CELL_RIGHT | CELL_SEEN;
                    if (n_side == SIDE_W) cell_wdata = CELL_DOWN | CELL_SEEN;
                    if (r_depth < DW'(TOTAL)) begin
                        stk_we = 1'b1;
                        n_depth = r_depth + DW'(1);
                    end
                    n_ovalid = 1'b1;
                    n_ev = EV_CARVE;
                    n_crow = 5'(pk_r);
                    n_ccol = 5'(pk_c);
                    n_frow = 5'(top_r);
                    n_fcol = 5'(top_c);
                    n_oside = n_side;
                    n_state = (n_side == SIDE_S || n_side == SIDE_E) ? S_WTOP : S_IDLE;
                end
            end
            S_WTOP: begin
                cell_we = 1'b1;
                cell_waddr = cidx(RW'(r_frow), CW'(r_fcol));
                cell_wdata = (r_oside == SIDE_S) ? (r_topv & ~CELL_DOWN) :
                                                   (r_topv & ~CELL_RIGHT);
                n_state = S_IDLE;
            end
            S_FIN: begin
                if (!out_busy) begin
                    n_ovalid = 1'b1;
                    n_ev = EV_FINISH;
                    n_crow = '0;
                    n_ccol = '0;
                    n_frow = '0;
                    n_fcol = '0;
                    n_oside = SIDE_N;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_pend <= 1'b0;
            r_running <= 1'b0;
            r_depth <= '0;
            r_ovalid <= 1'b0;
            r_rows_cfg <= CFG_RESET;
            r_cols_cfg <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pend <= (r_state == S_START) ? 1'b0 : n_pend;
            r_running <= n_running;
            r_depth <= n_depth;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROW_COUNT) r_rows_cfg <= i_cfg_data;
                if (i_cfg_idx == CFG_COL_COUNT) r_cols_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick <= n_pick;
        r_sr <= n_sr;
        r_sc <= n_sc;
        r_k <= n_k;
        r_mask <= n_mask;
        r_topv <= n_topv;
        r_ev <= n_ev;
        r_oside <= n_oside;
        r_crow <= n_crow;
        r_ccol <= n_ccol;
        r_frow <= n_frow;
        r_fcol <= n_fcol;
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) r_cell_mem[cell_waddr] <= cell_wdata;
        r_cell_q <= r_cell_mem[cell_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk_mem[stk_waddr] <= stk_wdata;
        r_stk_q <= r_stk_mem[stk_raddr];
    end

    assign o_out_valid = r_ovalid;
    assign o_event_res = r_ev;
    assign o_cell_row = r_crow;
    assign o_cell_col = r_ccol;
    assign o_from_row = r_frow;
    assign o_from_col = r_fcol;
    assign o_opened_side = r_oside;
endmodule

/* tb/testbench.sv */
// Self-checking testbench for maze_backtracker_carver: a queue-fed driver,
// a result monitor and a carving predictor with its own cell store.
// Depends on mbc_pkg and the maze_backtracker_carver RTL.
`timescale 1ns / 100ps

module testbench;
    import mbc_pkg::*;

    localparam int GRID_CELLS = MBC_MAX_ROWS * MBC_MAX_COLS;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic       mode;
        logic [4:0] start_row;
        logic [4:0] start_col;
        logic [7:0] pick;
    } t_maze_cmd;

    typedef struct packed {
        logic [1:0] ev;
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic [4:0] from_row;
        logic [4:0] from_col;
        logic [1:0] side;
    } t_carve_event;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_mode;
    logic [4:0]       i_start_row;
    logic [4:0]       i_start_col;
    logic [7:0]       i_random_pick;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [1:0]       o_event_res;
    logic [4:0]       o_cell_row;
    logic [4:0]       o_cell_col;
    logic [4:0]       o_from_row;
    logic [4:0]       o_from_col;
    logic [1:0]       o_opened_side;

    maze_backtracker_carver dut (.*);

    t_maze_cmd    cmd_queue[$];
    t_carve_event carve_queue[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           sender_idle = 0;
    int           receiver_stall = 0;
    logic         cmd_taken = 1'b0;

    // Predictor state.
    logic [CFG_W-1:0] row_reg = CFG_RESET;
    logic [CFG_W-1:0] col_reg = CFG_RESET;
    logic             seen[GRID_CELLS];
    logic             south_closed[GRID_CELLS];
    logic             east_closed[GRID_CELLS];
    int               path[GRID_CELLS];
    int               path_depth = 0;
    logic             carving = 1'b0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int clamp_count(logic [CFG_W-1:0] v, int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic void clear_grid();
        for (int i = 0; i < GRID_CELLS; i++) begin
            seen[i] = 1'b0;
            south_closed[i] = 1'b1;
            east_closed[i] = 1'b1;
        end
    endfunction

    function automatic t_carve_event predict_carve(t_maze_cmd cmd);
        t_carve_event res;
        int rows, cols, r, c, here, n, k, pick;
        int cand[4];
        int side[4];
        res = '0;
        rows = clamp_count(row_reg, MBC_MAX_ROWS);
        cols = clamp_count(col_reg, MBC_MAX_COLS);
        if (cmd.mode == MODE_START) begin
            r = (cmd.start_row > rows - 1) ? rows - 1 : cmd.start_row;
            c = (cmd.start_col > cols - 1) ? cols - 1 : cmd.start_col;
            clear_grid();
            here = r * MBC_MAX_COLS + c;
            seen[here] = 1'b1;
            path[0] = here;
            path_depth = 1;
            carving = 1'b1;
            res.ev = EV_START;
            res.cell_row = 5'(r);
            res.cell_col = 5'(c);
            return res;
        end
        if (carving) begin
            while (path_depth > 0) begin
                here = path[path_depth - 1];
                r = here / MBC_MAX_COLS;
                c = here % MBC_MAX_COLS;
                n = 0;
                if (r > 0 && !seen[here - MBC_MAX_COLS]) begin
                    cand[n] = here - MBC_MAX_COLS;
                    side[n] = SIDE_N;
                    n++;
                end
                if (c > 0 && !seen[here - 1]) begin
                    cand[n] = here - 1;
                    side[n] = SIDE_W;
                    n++;
                end
                if (r + 1 < rows && !seen[here + MBC_MAX_COLS]) begin
                    cand[n] = here + MBC_MAX_COLS;
                    side[n] = SIDE_S;
                    n++;
                end
                if (c + 1 < cols && !seen[here + 1]) begin
                    cand[n] = here + 1;
                    side[n] = SIDE_E;
                    n++;
                end
                if (n == 0) begin
                    path_depth--;
                    continue;
                end
                k = cmd.pick % n;
                pick = cand[k];
                seen[pick] = 1'b1;
                case (2'(side[k]))
                    SIDE_N: south_closed[pick] = 1'b0;
                    SIDE_W: east_closed[pick] = 1'b0;
                    SIDE_S: south_closed[here] = 1'b0;
                    default: east_closed[here] = 1'b0;
                endcase
                if (path_depth < GRID_CELLS) begin
                    path[path_depth] = pick;
                    path_depth++;
                end
                res.ev = EV_CARVE;
                res.cell_row = 5'(pick / MBC_MAX_COLS);
                res.cell_col = 5'(pick % MBC_MAX_COLS);
                res.from_row = 5'(r);
                res.from_col = 5'(c);
                res.side = 2'(side[k]);
                return res;
            end
            carving = 1'b0;
        end
        res.ev = EV_FINISH;
        return res;
    endfunction

    // Driver: loads the next command once the previous one has been transferred.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || cmd_taken) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= sender_idle) begin
                t_maze_cmd cmd;
                cmd = cmd_queue.pop_front();
                i_in_valid <= 1'b1;
                i_mode <= cmd.mode;
                i_start_row <= cmd.start_row;
                i_start_col <= cmd.start_col;
                i_random_pick <= cmd.pick;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= receiver_stall);
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        cmd_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            carve_queue = {carve_queue, predict_carve({i_mode, i_start_row, i_start_col,
                                                       i_random_pick})};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (carve_queue.size() == 0) begin
                $error("result with no expectation: event %0d", o_event_res);
                fail_count++;
            end else begin
                t_carve_event e;
                e = carve_queue.pop_front();
                if (o_event_res !== e.ev) begin
                    $error("event_res expected %0d got %0d", e.ev, o_event_res);
                    fail_count++;
                end
                if (o_cell_row !== e.cell_row) begin
                    $error("cell_row expected %0d got %0d", e.cell_row, o_cell_row);
                    fail_count++;
                end
                if (o_cell_col !== e.cell_col) begin
                    $error("cell_col expected %0d got %0d", e.cell_col, o_cell_col);
                    fail_count++;
                end
                if (o_from_row !== e.from_row) begin
                    $error("from_row expected %0d got %0d", e.from_row, o_from_row);
                    fail_count++;
                end
                if (o_from_col !== e.from_col) begin
                    $error("from_col expected %0d got %0d", e.from_col, o_from_col);
                    fail_count++;
                end
                if (o_opened_side !== e.side) begin
                    $error("opened_side expected %0d got %0d", e.side, o_opened_side);
                    fail_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_cmd(logic mode, int r, int c, int p);
        t_maze_cmd cmd;
        cmd = {mode, 5'(r), 5'(c), 8'(p)};
        cmd_queue = {cmd_queue, cmd};
    endtask

    task automatic drain();
        while (cmd_queue.size() > 0 || i_in_valid || carve_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_grid(int rows, int cols);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ROW_COUNT;
        i_cfg_data <= CFG_W'(rows);
        row_reg = CFG_W'(rows);
        @(negedge i_clk);
        i_cfg_idx <= CFG_COL_COUNT;
        i_cfg_data <= CFG_W'(cols);
        col_reg = CFG_W'(cols);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int random_count();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 32;
            3: return $urandom_range(33, 63);
            default: return $urandom_range(2, 7);
        endcase
    endfunction

    initial begin
        int rows, cols, steps, total;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ROW_COUNT;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = MODE_START;
        i_start_row = '0;
        i_start_col = '0;
        i_random_pick = '0;
        i_out_ready = 1'b0;
        clear_grid();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: step before any start, corner starts, pick extremes.
        add_cmd(1'b1, 0, 0, 0);
        add_cmd(MODE_START, 31, 31, 0);
        add_cmd(1'b1, 0, 0, 255);
        add_cmd(1'b1, 0, 0, 0);
        add_cmd(1'b1, 0, 0, 170);
        add_cmd(MODE_START, 0, 0, 85);
        add_cmd(1'b1, 0, 0, 255);
        add_cmd(1'b1, 0, 0, 1);
        drain();
        write_grid(0, 0);
        add_cmd(MODE_START, 31, 31, 0);
        add_cmd(1'b1, 0, 0, 7);
        add_cmd(1'b1, 0, 0, 7);
        drain();
        write_grid(2, 63);
        add_cmd(MODE_START, 31, 31, 0);
        for (int i = 0; i < 8; i++) add_cmd(1'b1, 0, 0, $urandom_range(255));
        drain();

        total = 0;
        for (int phase = 0; total < 850; phase++) begin
            sender_idle = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 74 : 31) : 0;
            receiver_stall = (phase % 4 == 2) ? 74 : ((phase % 4 == 3) ? 31 : 0);
            drain();
            rows = random_count();
            cols = random_count();
            if (rows >= 32 && cols >= 32) cols = $urandom_range(2, 6);
            write_grid(rows, cols);
            // A random half of the phases, those that skip the first start, keep carving the old maze on the new grid.
            for (int s = 0; s < 3 && total < 850; s++) begin
                if (s > 0 || $urandom_range(1)) begin
                    add_cmd(MODE_START, $urandom_range(31), $urandom_range(31), 0);
                    total++;
                end
                steps = $urandom_range(4, 40);
                for (int i = 0; i < steps; i++) begin
                    if ($urandom_range(29) == 0)
                        add_cmd(MODE_START, $urandom_range(31), $urandom_range(31),
                                $urandom_range(255));
                    else
                        add_cmd(1'b1, $urandom_range(31), $urandom_range(31),
                                $urandom_range(255));
                    total++;
                end
            end
        end
        drain();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
